@@ design/ergma_pkg.sv @@
// Package for the echo range gate moving average block.
// Holds field widths, the distance scale constant, register indexes and
// the status struct shared by the serial units. Depends on nothing.
package ergma_pkg;

   // Field widths
   localparam int ECHO_W      = 15;
   localparam int DIST_W      = 13;
   localparam int DIST_FULL_W = 14;

   // distance = (echo_us * 17983) >> 16, in 1/16 cm
   localparam int              MUL_W      = 15;
   localparam logic [MUL_W-1:0] DIST_MUL  = 15'd17983;
   localparam int              DIST_SHIFT = 16;
   localparam int              PROD_W     = ECHO_W + MUL_W;

   // Configuration port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 13;

   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_DISTANCE = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_DISTANCE = 1'b1;

   localparam logic [DIST_W-1:0] MIN_DISTANCE_RESET = 13'd32;
   localparam logic [DIST_W-1:0] MAX_DISTANCE_RESET = 13'd6400;

   localparam int FILTER_DEPTH_DEFAULT = 8;

   // Status of a multi-cycle serial unit
   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

endpackage

@@ design/echo_range_gate_moving_average_core.sv @@
// Top level of the echo range gate moving average block.
// Depends on ergma_pkg, ergma_ram, ergma_mult and ergma_div.
//
//   channel | ports                          | direction | word
//   --------+--------------------------------+-----------+---------------------------
//   req     | req_valid req_stall req_echo_us | in        | echo width, us (0=timeout)
//   rsp     | rsp_valid rsp_stall rsp_*       | out       | valid_res, altitude
//   csr     | csr_write csr_index csr_wdata   | in        | min/max distance write
//
// One word is processed at a time. A rejected word goes through bit-serial
// scaling, the done hand-off, the gate and the output load; the next word
// can then be taken. An accepted word adds the ring write, a read and an
// accumulate step per filled ring entry for the sum, a divide load, the
// bit-serial divide and its done hand-off before the output load.
// Reset is synchronous and clears the ring index, the full flag, the last
// average and the result valid; the ring RAM itself is not cleared.
// A waiting result in the output register does not block a new input word;
// only the final load of the next result waits for rsp_stall to drop.
module echo_range_gate_moving_average_core #(
   parameter int FILTER_DEPTH = ergma_pkg::FILTER_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // input words
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [ergma_pkg::ECHO_W-1:0]        req_echo_us,
   // result words
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_valid_res,
   output logic [ergma_pkg::DIST_W-1:0]        rsp_altitude,
   // register writes
   input  logic                                csr_write,
   input  logic [ergma_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [ergma_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int IDX_W = (FILTER_DEPTH > 1) ? $clog2(FILTER_DEPTH) : 1;
   localparam int CNT_W = $clog2(FILTER_DEPTH + 1);
   localparam int SUM_W = ergma_pkg::DIST_W + $clog2(FILTER_DEPTH);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MULT,
      ST_GATE,
      ST_WRITE,
      ST_READ,
      ST_ACC,
      ST_DIV_LOAD,
      ST_DIV,
      ST_OUT
   } state_type;

   state_type state_ff, state_in;

   logic                          echo_zero_ff, echo_zero_in;
   logic                          ok_ff, ok_in;
   logic [IDX_W-1:0]              wr_idx_ff, wr_idx_in;
   logic                          full_ff, full_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [IDX_W-1:0]              rd_idx_ff, rd_idx_in;
   logic [SUM_W-1:0]              sum_ff, sum_in;
   logic [ergma_pkg::DIST_W-1:0]  last_avg_ff, last_avg_in;
   logic [ergma_pkg::DIST_W-1:0]  min_ff, min_in;
   logic [ergma_pkg::DIST_W-1:0]  max_ff, max_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_res_ff, rsp_res_in;
   logic [ergma_pkg::DIST_W-1:0]  rsp_alt_ff, rsp_alt_in;

   // unit hookups
   logic                               mult_start;
   ergma_pkg::unit_stat_type           mult_stat;
   logic [ergma_pkg::DIST_FULL_W-1:0]  mult_dist;
   logic                               div_start;
   ergma_pkg::unit_stat_type           div_stat;
   logic [SUM_W-1:0]                   div_quo;
   logic                               ram_we;
   logic [ergma_pkg::DIST_W-1:0]       ram_rdata;

   logic in_range;
   logic wrap;

   ergma_mult u_mult (
      .clock    (clock),
      .reset    (reset),
      .start    (mult_start),
      .width_i  (req_echo_us),
      .stat     (mult_stat),
      .distance (mult_dist)
   );

   ergma_ram #(
      .WIDTH  (ergma_pkg::DIST_W),
      .DEPTH  (FILTER_DEPTH),
      .ADDR_W (IDX_W)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_idx_ff),
      .wr_data (mult_dist[ergma_pkg::DIST_W-1:0]),
      .rd_addr (rd_idx_ff),
      .rd_data (ram_rdata)
   );

   ergma_div #(
      .DIVIDEND_W (SUM_W),
      .DIVISOR_W  (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (count_ff),
      .stat     (div_stat),
      .quotient (div_quo)
   );

   // Gate on the full 14-bit distance so an overflowing one fails the max test.
   assign in_range = !echo_zero_ff
                  && (mult_dist >= {1'b0, min_ff})
                  && (mult_dist <= {1'b0, max_ff});
   assign wrap     = (wr_idx_ff == IDX_W'(FILTER_DEPTH - 1));

   assign mult_start = (state_ff == ST_IDLE) && req_valid;
   assign div_start  = (state_ff == ST_DIV_LOAD);
   assign ram_we     = (state_ff == ST_WRITE);

   always_comb begin
      state_in     = state_ff;
      echo_zero_in = echo_zero_ff;
      ok_in        = ok_ff;
      wr_idx_in    = wr_idx_ff;
      full_in      = full_ff;
      count_in     = count_ff;
      rd_idx_in    = rd_idx_ff;
      sum_in       = sum_ff;
      last_avg_in  = last_avg_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      rsp_res_in   = rsp_res_ff;
      rsp_alt_in   = rsp_alt_ff;

      // drop the result word once it is taken
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (csr_write) begin
         case (csr_index)
            ergma_pkg::CSR_MIN_DISTANCE: min_in = csr_wdata;
            ergma_pkg::CSR_MAX_DISTANCE: max_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               echo_zero_in = (req_echo_us == '0);
               state_in     = ST_MULT;
            end
         end
         ST_MULT: begin
            if (mult_stat.done) begin
               state_in = ST_GATE;
            end
         end
         ST_GATE: begin
            ok_in    = in_range;
            state_in = in_range ? ST_WRITE : ST_OUT;
         end
         ST_WRITE: begin
            // advance the ring pointer; count covers the slot just written
            wr_idx_in = wrap ? '0 : wr_idx_ff + IDX_W'(1);
            full_in   = full_ff || wrap;
            count_in  = (full_ff || wrap) ? CNT_W'(FILTER_DEPTH)
                                          : CNT_W'(wr_idx_ff) + CNT_W'(1);
            rd_idx_in = '0;
            sum_in    = '0;
            state_in  = ST_READ;
         end
         ST_READ: begin
            state_in = ST_ACC;
         end
         ST_ACC: begin
            sum_in = sum_ff + SUM_W'(ram_rdata);
            if (CNT_W'(rd_idx_ff) + CNT_W'(1) == count_ff) begin
               state_in = ST_DIV_LOAD;
            end else begin
               rd_idx_in = rd_idx_ff + IDX_W'(1);
               state_in  = ST_READ;
            end
         end
         ST_DIV_LOAD: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_stat.done) begin
               last_avg_in = div_quo[ergma_pkg::DIST_W-1:0];
               state_in    = ST_OUT;
            end
         end
         ST_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_res_in   = ok_ff;
               rsp_alt_in   = last_avg_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wr_idx_ff    <= '0;
         full_ff      <= 1'b0;
         last_avg_ff  <= '0;
         min_ff       <= ergma_pkg::MIN_DISTANCE_RESET;
         max_ff       <= ergma_pkg::MAX_DISTANCE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_idx_ff    <= wr_idx_in;
         full_ff      <= full_in;
         last_avg_ff  <= last_avg_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      echo_zero_ff <= echo_zero_in;
      ok_ff        <= ok_in;
      count_ff     <= count_in;
      rd_idx_ff    <= rd_idx_in;
      sum_ff       <= sum_in;
      rsp_res_ff   <= rsp_res_in;
      rsp_alt_ff   <= rsp_alt_in;
   end

   assign req_stall     = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_valid_res = rsp_res_ff;
   assign rsp_altitude  = rsp_alt_ff;

endmodule

@@ design/ergma_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module ergma_ram #(
   parameter int WIDTH  = 13,
   parameter int DEPTH  = 8,
   parameter int ADDR_W = 3
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/ergma_mult.sv @@
// Bit-serial distance scaler: echo width times the fixed scale factor,
// one multiplier bit per cycle. Depends on ergma_pkg.
module ergma_mult (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic [ergma_pkg::ECHO_W-1:0]          width_i,
   output ergma_pkg::unit_stat_type              stat,
   output logic [ergma_pkg::DIST_FULL_W-1:0]     distance
);

   localparam int CNT_W = $clog2(ergma_pkg::ECHO_W + 1);

   logic [ergma_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;

   logic [ergma_pkg::MUL_W-1:0] upper;
   logic [ergma_pkg::MUL_W-1:0] addend;
   logic [ergma_pkg::MUL_W:0]   psum;

   always_comb begin
      upper   = prod_ff[ergma_pkg::PROD_W-1:ergma_pkg::ECHO_W];
      addend  = prod_ff[0] ? ergma_pkg::DIST_MUL : '0;
      psum    = {1'b0, upper} + {1'b0, addend};
      prod_in = prod_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         prod_in = {{ergma_pkg::MUL_W{1'b0}}, width_i};
         cnt_in  = CNT_W'(ergma_pkg::ECHO_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // add on the low bit, then shift right
         prod_in = {psum, prod_ff[ergma_pkg::ECHO_W-1:1]};
         cnt_in  = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      prod_ff <= prod_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign distance  = prod_ff[ergma_pkg::PROD_W-1:ergma_pkg::DIST_SHIFT];

endmodule

@@ design/ergma_div.sv @@
// Restoring serial divider, one quotient bit per cycle.
// Depends on ergma_pkg.
module ergma_div #(
   parameter int DIVIDEND_W = 16,
   parameter int DIVISOR_W  = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [DIVIDEND_W-1:0]     dividend,
   input  logic [DIVISOR_W-1:0]      divisor,
   output ergma_pkg::unit_stat_type  stat,
   output logic [DIVIDEND_W-1:0]     quotient
);

   localparam int STEP_W = $clog2(DIVIDEND_W + 1);

   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dvs_ff, dvs_in;
   logic [STEP_W-1:0]     cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;

   logic [DIVISOR_W:0] trial;
   logic [DIVISOR_W:0] diff;
   logic               fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[DIVIDEND_W-1]};
      diff    = trial - {1'b0, dvs_ff};
      fits    = trial >= {1'b0, dvs_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = STEP_W'(DIVIDEND_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // bring down one dividend bit, subtract when the divisor fits
         rem_in = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
         cnt_in = cnt_ff - STEP_W'(1);
         if (cnt_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;

endmodule

@@ design/ergma_checker.sv @@
// Port-level checker for the echo range gate moving average block, with
// its bind to the top level. Depends on ergma_pkg.
module ergma_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic                          rsp_valid_res,
   input logic [ergma_pkg::DIST_W-1:0]  rsp_altitude
);

   // a stalled result word stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result word dropped while stalled");

   // a stalled result word keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_valid_res) && $stable(rsp_altitude))
      else $error("result payload changed while stalled");

   // one word in flight: input closes right after a word is taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input open in the cycle after an accept");

   // a new result appears only as the block goes back to idle
   a_result_ends_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !req_stall)
      else $error("result issued while still busy");

endmodule

bind echo_range_gate_moving_average_core ergma_checker u_checker (.*);

@@ sim/tb_echo_range_gate_moving_average_core.sv @@
// Testbench for echo_range_gate_moving_average_core: drives echo widths, predicts
// gated distance and ring mean per word, and checks every result word in order.
// Depends on ergma_pkg and the core RTL.
module tb_echo_range_gate_moving_average_core;
   import ergma_pkg::*;

   localparam int RING_DEPTH  = 8;
   localparam int HOLD_CYCLES = 300;   // long receiver hold-off
   localparam int QUIET_LIMIT = 4000;  // cycles with no handshake before giving up
   localparam int DRAIN_WAIT  = 64;    // cycles after the last result, past one full word

   typedef struct packed {
      logic              valid_res;
      logic [DIST_W-1:0] altitude;
   } altitude_word_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [ECHO_W-1:0]      req_echo_us = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic                   rsp_valid_res;
   logic [DIST_W-1:0]      rsp_altitude;
   logic                   csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_MIN_DISTANCE;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // Predictor state: gate registers, sample ring, write slot, wrap flag, held mean
   logic [DIST_W-1:0] gate_min;
   logic [DIST_W-1:0] gate_max;
   logic [DIST_W-1:0] echo_ring [RING_DEPTH];
   int                ring_wr_slot;
   logic              ring_wrapped;
   logic [DIST_W-1:0] held_altitude;

   altitude_word_type altitude_queue[$];
   altitude_word_type oldest;
   int  failures = 0;
   int  cycles_quiet = 0;
   bit  no_idle = 1'b0;
   int  hold_ask = 0;
   int  hold_seen = 0;
   int  hold_left = 0;

   echo_range_gate_moving_average_core #(
      .FILTER_DEPTH(RING_DEPTH)
   ) dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_echo_us  (req_echo_us),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_valid_res(rsp_valid_res),
      .rsp_altitude (rsp_altitude),
      .csr_write    (csr_write),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #4 clock = ~clock;

   // Clear the predictor to its post-reset state.
   task automatic clear_predictor();
      gate_min      = MIN_DISTANCE_RESET;
      gate_max      = MAX_DISTANCE_RESET;
      ring_wr_slot  = 0;
      ring_wrapped  = 1'b0;
      held_altitude = '0;
      for (int i = 0; i < RING_DEPTH; i++) echo_ring[i] = '0;
   endtask

   // Scale one echo width to distance, gate it, and update the running mean.
   function automatic altitude_word_type gate_and_average(input logic [ECHO_W-1:0] echo);
      logic [PROD_W-1:0]      prod;
      logic [DIST_FULL_W-1:0] distance;
      logic                   accept;
      int unsigned            sum;
      int                     count;
      altitude_word_type      word;
      prod     = PROD_W'(echo) * PROD_W'(DIST_MUL);
      distance = DIST_FULL_W'(prod >> DIST_SHIFT);
      // compare at full width: a 14-bit distance always fails the maximum test
      accept = (echo != '0) && (distance >= gate_min) && (distance <= gate_max);
      if (accept) begin
         echo_ring[ring_wr_slot] = distance[DIST_W-1:0];
         if (ring_wr_slot == RING_DEPTH - 1) begin
            ring_wr_slot = 0;
            ring_wrapped = 1'b1;
         end else begin
            ring_wr_slot++;
         end
         count = ring_wrapped ? RING_DEPTH : ring_wr_slot;
         sum   = 0;
         for (int i = 0; i < count; i++) sum += echo_ring[i];
         held_altitude = DIST_W'(sum / count);
      end
      word.valid_res = accept;
      word.altitude  = held_altitude;
      return word;
   endfunction

   // Offer one echo word, idling at random first; leave valid high on return.
   task automatic send_echo(input logic [ECHO_W-1:0] echo);
      while (!no_idle && $urandom_range(0, 99) < 28) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_echo_us <= echo;
      do @(posedge clock); while (req_stall);
      altitude_queue.push_back(gate_and_average(echo));
   endtask

   // Drop valid and wait until every expected word has come back.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (altitude_queue.size() != 0) @(posedge clock);
   endtask

   // Write both gate registers on back-to-back edges; block must be idle.
   task automatic set_gate(input logic [DIST_W-1:0] lo, input logic [DIST_W-1:0] hi);
      wait_for_results();
      csr_write <= 1'b1;
      csr_index <= CSR_MIN_DISTANCE;
      csr_wdata <= lo;
      @(posedge clock);
      gate_min   = lo;
      csr_index <= CSR_MAX_DISTANCE;
      csr_wdata <= hi;
      @(posedge clock);
      gate_max   = hi;
      csr_write <= 1'b0;
   endtask

   // Pick an echo width: often near a gate edge, some timeouts and short widths, wide and plain values.
   function automatic logic [ECHO_W-1:0] pick_echo();
      int mode;
      int bound;
      int echo;
      mode = $urandom_range(0, 99);
      if (mode < 8) return '0;
      if (mode < 16) return ECHO_W'($urandom_range(1, 300));
      if (mode < 64) begin
         bound = (mode < 40) ? int'(gate_min) : int'(gate_max);
         echo  = (bound * 65536 + 17982) / 17983 + int'($urandom_range(0, 8)) - 4;
         if (echo < 0) echo = 0;
         if (echo > 32767) echo = 32767;
         return ECHO_W'(echo);
      end
      if (mode < 69) return ECHO_W'($urandom_range(25001, 32767));
      return ECHO_W'($urandom_range(0, 25000));
   endfunction

   // Reset values of the gate: timeout, below-minimum, edge and above-maximum words.
   task automatic test_reset_gate();
      send_echo(15'd0);
      send_echo(15'd116);
      send_echo(15'd117);
      send_echo(15'd25000);
   endtask

   // A zero width is a timeout even with the minimum at zero.
   task automatic test_timeout();
      set_gate(13'd0, 13'd8191);
      send_echo(15'd0);
      send_echo(15'd1);
   endtask

   // Widths around the point where the distance crosses into the fourteenth bit.
   task automatic test_wide_distance();
      send_echo(15'd29854);
      send_echo(15'd29855);
      send_echo(15'd32767);
   endtask

   // Run past one wrap of the ring so the mean covers every slot.
   task automatic test_ring_wrap();
      logic [ECHO_W-1:0] widths [9] = '{15'd25000, 15'd16384, 15'd1, 15'd12345,
                                        15'd21845, 15'd10922, 15'd8191, 15'd3000,
                                        15'd24999};
      foreach (widths[i]) send_echo(widths[i]);
   endtask

   // Minimum above maximum: nothing passes, altitude holds.
   task automatic test_inverted_gate();
      set_gate(13'd8191, 13'd0);
      send_echo(15'd1);
      send_echo(15'd25000);
   endtask

   // A one-value window: only widths that land exactly on it pass.
   task automatic test_single_value_gate();
      set_gate(13'd2000, 13'd2000);
      send_echo(15'd7288);
      send_echo(15'd7289);
      send_echo(15'd7290);
      send_echo(15'd7292);
   endtask

   // Hold the receiver off while words keep coming, so the core backs up its input.
   task automatic test_receiver_hold();
      set_gate(MIN_DISTANCE_RESET, MAX_DISTANCE_RESET);
      hold_ask <= hold_ask + 1;
      repeat (12) send_echo(pick_echo());
   endtask

   // Random words over a series of gate settings, one phase without idling.
   task automatic test_random_gates();
      int lo;
      int hi;
      int items;
      for (int phase = 0; phase < 9; phase++) begin
         items = 70;
         case (phase)
            0: begin
               lo = 32;   hi = 6400;
            end
            1: begin
               lo = 0;    hi = 8191;
            end
            2: begin
               lo = $urandom_range(0, 3000);
               hi = $urandom_range(lo, 8191);
            end
            3: begin
               lo = $urandom_range(0, 6000);
               hi = lo + $urandom_range(0, 40);
            end
            4: begin
               lo = 8191; hi = 8191;
            end
            5: begin
               lo = 0;    hi = 0;
            end
            6: begin
               lo = $urandom_range(1000, 8191);
               hi = $urandom_range(0, lo - 1);
               items = 30;
            end
            default: begin
               lo = $urandom_range(0, 8191);
               hi = $urandom_range(0, 8191);
            end
         endcase
         set_gate(DIST_W'(lo), DIST_W'(hi));
         no_idle = (phase == 1);
         repeat (items) send_echo(pick_echo());
      end
      no_idle = 1'b0;
   endtask

   // Receiver: random stall, long hold-off on request, none in the no-idle stretch.
   always @(posedge clock) begin
      if (hold_ask != hold_seen) begin
         hold_seen <= hold_ask;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (no_idle) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < 28);
      end
   end

   // Compare each accepted result word with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (altitude_queue.size() == 0) begin
            $display("%0t: unexpected result: valid_res %0b altitude %0d",
                     $time, rsp_valid_res, rsp_altitude);
            failures++;
         end else begin
            oldest = altitude_queue.pop_front();
            if (rsp_valid_res !== oldest.valid_res) begin
               $display("%0t: valid_res mismatch: expected %0b actual %0b",
                        $time, oldest.valid_res, rsp_valid_res);
               failures++;
            end
            if (rsp_altitude !== oldest.altitude) begin
               $display("%0t: altitude mismatch: expected %0d actual %0d",
                        $time, oldest.altitude, rsp_altitude);
               failures++;
            end
         end
      end
   end

   // Watchdog: count cycles with no handshake on either channel.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         cycles_quiet <= 0;
      end else begin
         cycles_quiet <= cycles_quiet + 1;
         if (cycles_quiet >= QUIET_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin
      clear_predictor();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_gate();
      test_timeout();
      test_wide_distance();
      test_ring_wrap();
      test_inverted_gate();
      test_single_value_gate();
      test_receiver_hold();
      test_random_gates();
      wait_for_results();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (failures == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
